// ===== rtl/ps2md_pkg.sv =====
`default_nettype none

package ps2md_pkg;

    // Input item kinds (s_tuser)
    localparam logic [1:0] FUNC_RX      = 2'd0;
    localparam logic [1:0] FUNC_SET_POS = 2'd1;
    localparam logic [1:0] FUNC_SET_BTN = 2'd2;

    // Protocol modes
    localparam logic [1:0] MODE_LEGACY   = 2'd0;
    localparam logic [1:0] MODE_WHEEL    = 2'd1;
    localparam logic [1:0] MODE_EXPLORER = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam int CFG_DATA_W = 13;
    localparam int BOUND_W    = 13;
    localparam int POS_W      = 13;
    localparam int BTN_W      = 5;
    localparam int BTN_NUM_W  = 3;
    localparam int WV_W       = 8;
    localparam int WH_W       = 2;

    localparam logic [BOUND_W-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [BOUND_W-1:0] HEIGHT_RESET = 13'd1080;

    // Status byte fields
    localparam int         SYNC_BIT  = 3;
    localparam int         XSIGN_BIT = 4;
    localparam int         YSIGN_BIT = 5;
    localparam logic [7:0] OVF_MASK  = 8'hC0;
    localparam logic [7:0] BTN_MASK  = 8'h07;

    // Explorer byte fields
    localparam int HTICK_RIGHT_BIT = 5;
    localparam int HTICK_LEFT_BIT  = 4;

    // Pending event slots, lowest goes first
    localparam int PEND_W      = 7;
    localparam int PEND_MOVE   = 0;
    localparam int PEND_SCROLL = 1;
    localparam int PEND_BTN0   = 2;

    typedef enum logic [1:0] {
        EV_MOVE   = 2'd0,
        EV_SCROLL = 2'd1,
        EV_DOWN   = 2'd2,
        EV_UP     = 2'd3
    } event_kind_t;

endpackage

`default_nettype wire

// ===== rtl/ps2md_clamp.sv =====
`default_nettype none

module ps2md_clamp #(
    parameter int COORD_BITS = 12,
    parameter int CALC_W     = 15
) (
    input  wire logic signed [CALC_W-1:0]               value_i,
    input  wire logic [ps2md_pkg::BOUND_W-1:0]          bound_i,
    output logic [COORD_BITS-1:0]                       clamped_o
);

    localparam logic signed [CALC_W-1:0] TOP =
        {{(CALC_W-1){1'b0}}, 1'b1} << COORD_BITS;
    localparam logic signed [CALC_W-1:0] ONE = {{(CALC_W-1){1'b0}}, 1'b1};

    logic signed [CALC_W-1:0] bound_ext;
    logic signed [CALC_W-1:0] lim;
    logic signed [CALC_W-1:0] lim_m1;

    always_comb begin
        bound_ext = {{(CALC_W-ps2md_pkg::BOUND_W){1'b0}}, bound_i};
        if (bound_i == '0) begin
            lim = ONE;
        end else if (bound_ext > TOP) begin
            lim = TOP;
        end else begin
            lim = bound_ext;
        end
        lim_m1 = lim - ONE;
        if (value_i < 0) begin
            clamped_o = '0;
        end else if (value_i >= lim) begin
            clamped_o = lim_m1[COORD_BITS-1:0];
        end else begin
            clamped_o = value_i[COORD_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ps2_mouse_packet_decoder_core.sv =====
`default_nettype none

// Channel  | dir | handshake               | payload
// s_       | in  | s_tvalid / s_tready     | s_tuser: func; s_tdata: data_byte, new_x, new_y
// m_       | out | m_tvalid / m_tready     | m_tuser: event_kind; m_tlast: last_event;
//          |     |                         | m_tdata: cursor, buttons, wheel, button_number
// cfg_     | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data (always ready)
//
// An item goes input register -> decode -> pending event set -> output register.
// Items that cause no event are taken one per cycle while nothing is pending; a packet with
// events holds the input while the pending set drains one event a cycle when m_ is not stalled.
// aresetn is synchronous: control, cursor and buttons clear, config registers take reset values; no sweep.

module ps2_mouse_packet_decoder_core #(
    parameter int COORD_BITS = 12
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // data_byte[7:0], new_x[20:8], new_y[33:21]
    input  wire logic [1:0]  s_tuser,   // func

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // cursor_x, cursor_y, button_bits, wheel_vertical, wheel_horizontal, button_number
    output logic [((2*COORD_BITS+18+7)/8)*8-1:0] m_tdata,
    output logic [1:0]       m_tuser,   // event_kind
    output logic             m_tlast,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [ps2md_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int OUT_BITS = 2*COORD_BITS + 18;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int CALC_W   = ((COORD_BITS > 13) ? COORD_BITS : 13) + 2;

    // configuration
    logic [1:0]                          mode_reg;
    logic [ps2md_pkg::BOUND_W-1:0]       width_reg;
    logic [ps2md_pkg::BOUND_W-1:0]       height_reg;

    // input stage
    logic                                in_valid_reg;
    logic [1:0]                          in_func_reg;
    logic [7:0]                          in_data_reg;
    logic [ps2md_pkg::POS_W-1:0]         in_x_reg;
    logic [ps2md_pkg::POS_W-1:0]         in_y_reg;

    // decoder state
    logic [1:0]                          bytepos_reg;
    logic [1:0]                          bytepos_next;
    logic [7:0]                          pkt_reg [3];
    logic [COORD_BITS-1:0]               cur_x_reg;
    logic [COORD_BITS-1:0]               cur_y_reg;
    logic [ps2md_pkg::BTN_W-1:0]         btn_reg;
    logic [COORD_BITS-1:0]               cur_x_next;
    logic [COORD_BITS-1:0]               cur_y_next;
    logic [ps2md_pkg::BTN_W-1:0]         btn_next;

    // pending events
    logic [ps2md_pkg::PEND_W-1:0]        pend_reg;
    logic [ps2md_pkg::PEND_W-1:0]        pend_next;
    logic [COORD_BITS-1:0]               snap_x_reg;
    logic [COORD_BITS-1:0]               snap_y_reg;
    logic [ps2md_pkg::BTN_W-1:0]         snap_btn_reg;
    logic [ps2md_pkg::WV_W-1:0]          snap_wv_reg;
    logic [ps2md_pkg::WH_W-1:0]          snap_wh_reg;

    // output register
    logic                                out_valid_reg;
    logic [1:0]                          out_kind_reg;
    logic                                out_last_reg;
    logic [COORD_BITS-1:0]               out_x_reg;
    logic [COORD_BITS-1:0]               out_y_reg;
    logic [ps2md_pkg::BTN_W-1:0]         out_btn_reg;
    logic [ps2md_pkg::WV_W-1:0]          out_wv_reg;
    logic [ps2md_pkg::WH_W-1:0]          out_wh_reg;
    logic [ps2md_pkg::BTN_NUM_W-1:0]     out_bn_reg;

    // decode
    logic                                pend_empty;
    logic                                decode_fire;
    logic [2:0]                          pos_inc;
    logic                                is_rx;
    logic                                take_byte;
    logic                                len4;
    logic                                complete;
    logic                                apply;
    logic [7:0]                          stat;
    logic [7:0]                          b2;
    logic [8:0]                          dx;
    logic [8:0]                          dy;
    logic                                drop;
    logic [ps2md_pkg::WV_W-1:0]          wv;
    logic [ps2md_pkg::WH_W-1:0]          wh;
    logic [1:0]                          extra;
    logic [ps2md_pkg::BTN_W-1:0]         pkt_btn;
    logic [ps2md_pkg::BTN_W-1:0]         changed;
    logic [ps2md_pkg::PEND_W-1:0]        pend_new;
    logic signed [CALC_W-1:0]            val_x;
    logic signed [CALC_W-1:0]            val_y;
    logic [COORD_BITS-1:0]               clamp_x;
    logic [COORD_BITS-1:0]               clamp_y;

    // emitter
    logic                                load_out;
    logic [ps2md_pkg::PEND_W-1:0]        sel_onehot;
    logic [2:0]                          sel_idx;
    logic [ps2md_pkg::BTN_NUM_W-1:0]     sel_bn;
    logic [1:0]                          sel_kind;
    logic                                sel_last;

    assign cfg_ready   = 1'b1;
    assign pend_empty  = (pend_reg == '0);
    assign decode_fire = in_valid_reg && pend_empty;
    assign s_tready    = !in_valid_reg || pend_empty;
    assign load_out    = !pend_empty && (!out_valid_reg || m_tready);

    always_comb begin
        pos_inc   = {1'b0, bytepos_reg} + 3'd1;
        is_rx     = (in_func_reg == ps2md_pkg::FUNC_RX);
        take_byte = is_rx && ((bytepos_reg != 2'd0) || in_data_reg[ps2md_pkg::SYNC_BIT]);
        len4      = (mode_reg == ps2md_pkg::MODE_WHEEL) ||
                    (mode_reg == ps2md_pkg::MODE_EXPLORER);
        complete  = take_byte && (pos_inc >= (len4 ? 3'd4 : 3'd3));

        stat = pkt_reg[0];
        b2   = (bytepos_reg == 2'd2) ? in_data_reg : pkt_reg[2];
        dx   = {stat[ps2md_pkg::XSIGN_BIT], pkt_reg[1]};
        dy   = {stat[ps2md_pkg::YSIGN_BIT], b2};
        drop = |(stat & ps2md_pkg::OVF_MASK);

        wv    = '0;
        wh    = '0;
        extra = '0;
        if (mode_reg == ps2md_pkg::MODE_WHEEL) begin
            wv = 8'd0 - in_data_reg;
        end else if (mode_reg == ps2md_pkg::MODE_EXPLORER) begin
            wv    = 8'd0 - {{4{in_data_reg[3]}}, in_data_reg[3:0]};
            extra = in_data_reg[7:6];
            if (in_data_reg[ps2md_pkg::HTICK_LEFT_BIT]) begin
                wh = 2'b11;
            end else if (in_data_reg[ps2md_pkg::HTICK_RIGHT_BIT]) begin
                wh = 2'b01;
            end
        end

        apply   = complete && !drop;
        pkt_btn = {extra, stat[2:0] & ps2md_pkg::BTN_MASK[2:0]};
        changed = pkt_btn ^ btn_reg;
        pend_new = '0;
        if (apply) begin
            pend_new[ps2md_pkg::PEND_MOVE]   = (dx != '0) || (dy != '0);
            pend_new[ps2md_pkg::PEND_SCROLL] = (wv != '0) || (wh != '0);
            pend_new[ps2md_pkg::PEND_W-1:ps2md_pkg::PEND_BTN0] = changed;
        end

        if (in_func_reg == ps2md_pkg::FUNC_SET_POS) begin
            val_x = {{(CALC_W-ps2md_pkg::POS_W){in_x_reg[ps2md_pkg::POS_W-1]}}, in_x_reg};
            val_y = {{(CALC_W-ps2md_pkg::POS_W){in_y_reg[ps2md_pkg::POS_W-1]}}, in_y_reg};
        end else begin
            val_x = {{(CALC_W-COORD_BITS){1'b0}}, cur_x_reg} + {{(CALC_W-9){dx[8]}}, dx};
            val_y = {{(CALC_W-COORD_BITS){1'b0}}, cur_y_reg} - {{(CALC_W-9){dy[8]}}, dy};
        end

        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        btn_next     = btn_reg;
        bytepos_next = bytepos_reg;
        unique case (in_func_reg)
            ps2md_pkg::FUNC_SET_POS: begin
                cur_x_next = clamp_x;
                cur_y_next = clamp_y;
            end
            ps2md_pkg::FUNC_SET_BTN: begin
                btn_next = in_data_reg[ps2md_pkg::BTN_W-1:0];
            end
            ps2md_pkg::FUNC_RX: begin
                if (take_byte) begin
                    bytepos_next = complete ? 2'd0 : pos_inc[1:0];
                end
                if (apply) begin
                    cur_x_next = clamp_x;
                    cur_y_next = clamp_y;
                    btn_next   = pkt_btn;
                end
            end
            default: begin
            end
        endcase
    end

    ps2md_clamp #(
        .COORD_BITS (COORD_BITS),
        .CALC_W     (CALC_W)
    ) u_clamp_x (
        .value_i   (val_x),
        .bound_i   (width_reg),
        .clamped_o (clamp_x)
    );

    ps2md_clamp #(
        .COORD_BITS (COORD_BITS),
        .CALC_W     (CALC_W)
    ) u_clamp_y (
        .value_i   (val_y),
        .bound_i   (height_reg),
        .clamped_o (clamp_y)
    );

    // lowest pending event first
    always_comb begin
        sel_onehot = pend_reg & (~pend_reg + 1'b1);
        sel_idx    = '0;
        for (int i = ps2md_pkg::PEND_W - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel_idx = 3'(i);
            end
        end
        sel_last = ((pend_reg & ~sel_onehot) == '0);
        sel_bn   = '0;
        if (sel_idx == 3'(ps2md_pkg::PEND_MOVE)) begin
            sel_kind = ps2md_pkg::EV_MOVE;
        end else if (sel_idx == 3'(ps2md_pkg::PEND_SCROLL)) begin
            sel_kind = ps2md_pkg::EV_SCROLL;
        end else begin
            sel_bn   = sel_idx - 3'(ps2md_pkg::PEND_BTN0);
            sel_kind = snap_btn_reg[sel_bn] ? ps2md_pkg::EV_DOWN : ps2md_pkg::EV_UP;
        end
        pend_next = pend_reg;
        if (decode_fire) begin
            pend_next = pend_new;
        end else if (load_out) begin
            pend_next = pend_reg & ~sel_onehot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= ps2md_pkg::MODE_LEGACY;
            width_reg     <= ps2md_pkg::WIDTH_RESET;
            height_reg    <= ps2md_pkg::HEIGHT_RESET;
            in_valid_reg  <= 1'b0;
            bytepos_reg   <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            btn_reg       <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    ps2md_pkg::REG_MODE:   mode_reg   <= cfg_data[1:0];
                    ps2md_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                    ps2md_pkg::REG_HEIGHT: height_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (decode_fire) begin
                bytepos_reg <= bytepos_next;
                cur_x_reg   <= cur_x_next;
                cur_y_reg   <= cur_y_next;
                btn_reg     <= btn_next;
            end
            pend_reg <= pend_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg <= s_tuser;
            in_data_reg <= s_tdata[7:0];
            in_x_reg    <= s_tdata[20:8];
            in_y_reg    <= s_tdata[33:21];
        end
        if (decode_fire && take_byte && (bytepos_reg != 2'd3)) begin
            pkt_reg[bytepos_reg] <= in_data_reg;
        end
        if (decode_fire && apply) begin
            snap_x_reg   <= clamp_x;
            snap_y_reg   <= clamp_y;
            snap_btn_reg <= pkt_btn;
            snap_wv_reg  <= wv;
            snap_wh_reg  <= wh;
        end
        if (load_out) begin
            out_kind_reg <= sel_kind;
            out_last_reg <= sel_last;
            out_x_reg    <= snap_x_reg;
            out_y_reg    <= snap_y_reg;
            out_btn_reg  <= snap_btn_reg;
            out_wv_reg   <= (sel_kind == ps2md_pkg::EV_SCROLL) ? snap_wv_reg : '0;
            out_wh_reg   <= (sel_kind == ps2md_pkg::EV_SCROLL) ? snap_wh_reg : '0;
            out_bn_reg   <= sel_bn;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, out_bn_reg, out_wh_reg, out_wv_reg,
                       out_btn_reg, out_y_reg, out_x_reg};

    a_pend_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (!pend_empty && (!out_valid_reg || m_tready)) |=> out_valid_reg)
        else $error("pending event not moved to output");

    a_more_after_nonlast: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && m_tready && !out_last_reg) |-> !pend_empty)
        else $error("non-final event with nothing pending");

    a_no_decode_while_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (!pend_empty && !load_out) |=> $stable(pend_reg))
        else $error("pending set changed without a load");

    a_scroll_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_kind_reg != ps2md_pkg::EV_SCROLL)) |->
        (out_wv_reg == '0) && (out_wh_reg == '0))
        else $error("wheel value on a non-scroll event");

endmodule

`default_nettype wire
